### hdl/bilinear_image_resampler_macros.svh
// Assertion macros shared by the resampler modules.
`ifndef BILINEAR_IMAGE_RESAMPLER_MACROS_SVH
`define BILINEAR_IMAGE_RESAMPLER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BIR_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("same-cycle implication violated");
// Next-cycle implication, disabled during reset.
`define BIR_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle implication violated");
`else
`define BIR_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define BIR_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

### hdl/bir_pkg.sv
package bir_pkg;

    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int MAX_DST_SIDE   = 1024;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DST_W       = (MAX_DST_SIDE > 1) ? $clog2(MAX_DST_SIDE) : 1;

    localparam int SW_W   = 9;
    localparam int SH_W   = 9;
    localparam int DW_W   = 11;
    localparam int STEP_W = 23;
    localparam int POS_W  = 24;
    localparam int FRAC_W = 15;
    localparam int INT_W  = POS_W - FRAC_W;
    localparam int WGT_W  = FRAC_W + 1;
    localparam int PROD_W = SW_W + SH_W;
    localparam int CH_W   = 8;
    localparam int NUM_CH = 4;
    localparam int PIX_W  = CH_W * NUM_CH;

    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP_U     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STEP_V     = 3'd5;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

    localparam logic [SW_W-1:0] SRC_W_MIN = SW_W'(2);
    localparam logic [SW_W-1:0] SRC_W_MAX =
        SW_W'((MAX_SRC_WIDTH > 511) ? 511 : MAX_SRC_WIDTH);
    localparam logic [SH_W-1:0] SRC_H_MIN = SH_W'(2);
    localparam logic [SH_W-1:0] SRC_H_MAX =
        SH_W'((MAX_SRC_HEIGHT > 511) ? 511 : MAX_SRC_HEIGHT);
    localparam logic [DW_W-1:0] DST_MIN = DW_W'(1);
    localparam logic [DW_W-1:0] DST_MAX =
        DW_W'((MAX_DST_SIDE > 2047) ? 2047 : MAX_DST_SIDE);

    localparam logic [WGT_W-1:0] FRAC_ONE = 16'h8000;

    typedef struct packed {
        logic [SW_W-1:0]   src_width;
        logic [SH_W-1:0]   src_height;
        logic [DW_W-1:0]   dst_width;
        logic [DW_W-1:0]   dst_height;
        logic [STEP_W-1:0] step_u;
        logic [STEP_W-1:0] step_v;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        src_width:  9'd256,
        src_height: 9'd256,
        dst_width:  11'd256,
        dst_height: 11'd256,
        step_u:     23'd32768,
        step_v:     23'd32768
    };

    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_C,
        SEL_D
    } sel_t;

    typedef struct packed {
        logic load;
        logic read;
        sel_t sel;
        logic latch_a;
        logic calc_top;
        logic latch_c;
        logic calc_bot;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [PROD_W-1:0] v);
        return ADDR_W'(v);
    endfunction

endpackage

### hdl/bir_regs.sv
module bir_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bir_pkg::APB_AW-1:0]  paddr,
    input  logic [bir_pkg::APB_DW-1:0]  pwdata,
    output logic [bir_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output bir_pkg::cfg_t               cfg
);

    bir_pkg::cfg_t                       cfg_reg;
    bir_pkg::cfg_t                       cfg_next;
    logic                                wr_en;
    logic [bir_pkg::REG_IDX_W-1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[bir_pkg::APB_AW-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                bir_pkg::REG_SRC_WIDTH:  cfg_next.src_width  = pwdata[bir_pkg::SW_W-1:0];
                bir_pkg::REG_SRC_HEIGHT: cfg_next.src_height = pwdata[bir_pkg::SH_W-1:0];
                bir_pkg::REG_DST_WIDTH:  cfg_next.dst_width  = pwdata[bir_pkg::DW_W-1:0];
                bir_pkg::REG_DST_HEIGHT: cfg_next.dst_height = pwdata[bir_pkg::DW_W-1:0];
                bir_pkg::REG_STEP_U:     cfg_next.step_u     = pwdata[bir_pkg::STEP_W-1:0];
                bir_pkg::REG_STEP_V:     cfg_next.step_v     = pwdata[bir_pkg::STEP_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            bir_pkg::REG_SRC_WIDTH:  prdata = 32'(cfg_reg.src_width);
            bir_pkg::REG_SRC_HEIGHT: prdata = 32'(cfg_reg.src_height);
            bir_pkg::REG_DST_WIDTH:  prdata = 32'(cfg_reg.dst_width);
            bir_pkg::REG_DST_HEIGHT: prdata = 32'(cfg_reg.dst_height);
            bir_pkg::REG_STEP_U:     prdata = 32'(cfg_reg.step_u);
            bir_pkg::REG_STEP_V:     prdata = 32'(cfg_reg.step_v);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= bir_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/bir_ctrl.sv
`include "bilinear_image_resampler_macros.svh"

module bir_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            mode,
    output logic            s_tready,
    input  bir_pkg::stat_t  stat,
    output bir_pkg::cmd_t   cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RDB  = 6'b000010,
        ST_RDC  = 6'b000100,
        ST_RDD  = 6'b001000,
        ST_BOT  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.sel      = bir_pkg::SEL_A;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (mode == bir_pkg::MODE_EMIT)
                    begin
                        cmd.read   = 1'b1;
                        cmd.sel    = bir_pkg::SEL_A;
                        state_next = ST_RDB;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_RDB:
            begin
                cmd.read    = 1'b1;
                cmd.sel     = bir_pkg::SEL_B;
                cmd.latch_a = 1'b1;
                state_next  = ST_RDC;
            end
            ST_RDC:
            begin
                cmd.read     = 1'b1;
                cmd.sel      = bir_pkg::SEL_C;
                cmd.calc_top = 1'b1;
                state_next   = ST_RDD;
            end
            ST_RDD:
            begin
                cmd.read    = 1'b1;
                cmd.sel     = bir_pkg::SEL_D;
                cmd.latch_c = 1'b1;
                state_next  = ST_BOT;
            end
            ST_BOT:
            begin
                cmd.calc_bot = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `BIR_ASSERT_NXT(a_emit_starts_reads, clk, rst_n, s_tvalid && s_tready && (mode == bir_pkg::MODE_EMIT), state_reg == ST_RDB)
    `BIR_ASSERT_NXT(a_finish_returns_idle, clk, rst_n, cmd.finish, state_reg == ST_IDLE)

endmodule

### hdl/bir_dp.sv
`include "bilinear_image_resampler_macros.svh"

module bir_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bir_pkg::cfg_t               cfg,
    input  bir_pkg::cmd_t               cmd,
    output bir_pkg::stat_t              stat,
    input  logic [bir_pkg::PIX_W-1:0]   in_pixel,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bir_pkg::PIX_W-1:0]   m_tdata,
    output logic [0:0]                  m_tuser,
    output logic                        m_tlast
);

    function automatic logic [bir_pkg::CH_W-1:0] lerp(
        input logic [bir_pkg::CH_W-1:0]   p,
        input logic [bir_pkg::CH_W-1:0]   q,
        input logic [bir_pkg::FRAC_W-1:0] w
    );
        logic [bir_pkg::WGT_W-1:0]                wl;
        logic [bir_pkg::WGT_W-1:0]                wr;
        logic [bir_pkg::CH_W+bir_pkg::WGT_W-1:0]  s;
        wl = bir_pkg::FRAC_ONE - {1'b0, w};
        wr = {1'b0, w};
        s  = {{bir_pkg::WGT_W{1'b0}}, p} * {{bir_pkg::CH_W{1'b0}}, wl}
           + {{bir_pkg::WGT_W{1'b0}}, q} * {{bir_pkg::CH_W{1'b0}}, wr};
        return s[bir_pkg::FRAC_W+bir_pkg::CH_W-1:bir_pkg::FRAC_W];
    endfunction

    logic [bir_pkg::PIX_W-1:0]   store_mem [bir_pkg::STORE_DEPTH];
    logic [bir_pkg::PIX_W-1:0]   rd_data_reg;

    logic [bir_pkg::SW_W-1:0]    sw;
    logic [bir_pkg::SH_W-1:0]    sh;
    logic [bir_pkg::DW_W-1:0]    dw;
    logic [bir_pkg::DW_W-1:0]    dh;
    logic [bir_pkg::SW_W-1:0]    sw_m1;
    logic [bir_pkg::SH_W-1:0]    sh_m1;
    logic [bir_pkg::PROD_W-1:0]  area;

    logic [bir_pkg::ADDR_W-1:0]  load_idx_reg;
    logic [bir_pkg::ADDR_W-1:0]  load_idx_next;
    logic [bir_pkg::ADDR_W-1:0]  ld_cur;
    logic [bir_pkg::ADDR_W:0]    ld_inc;

    logic [bir_pkg::DST_W-1:0]   col_reg;
    logic [bir_pkg::DST_W-1:0]   col_next;
    logic [bir_pkg::DST_W-1:0]   row_reg;
    logic [bir_pkg::DST_W-1:0]   row_next;
    logic [bir_pkg::DST_W:0]     col_p1;
    logic [bir_pkg::DST_W:0]     row_p1;
    logic                        last_col;
    logic                        last_row;

    logic [bir_pkg::POS_W-1:0]   u_reg;
    logic [bir_pkg::POS_W-1:0]   u_next;
    logic [bir_pkg::POS_W-1:0]   v_reg;
    logic [bir_pkg::POS_W-1:0]   v_next;
    logic [bir_pkg::FRAC_W-1:0]  xw;
    logic [bir_pkg::FRAC_W-1:0]  yw;
    logic [bir_pkg::INT_W-1:0]   x_int;
    logic [bir_pkg::INT_W-1:0]   y_int;
    logic [bir_pkg::SW_W-1:0]    x0;
    logic [bir_pkg::SW_W-1:0]    x1;
    logic [bir_pkg::SH_W-1:0]    y0;
    logic [bir_pkg::SH_W-1:0]    y1;
    logic [bir_pkg::PROD_W-1:0]  row0_base;
    logic [bir_pkg::PROD_W-1:0]  row1_base;
    logic [bir_pkg::PROD_W-1:0]  rd_sum;
    logic [bir_pkg::ADDR_W-1:0]  rd_addr;

    logic [bir_pkg::PIX_W-1:0]   a_reg;
    logic [bir_pkg::PIX_W-1:0]   a_next;
    logic [bir_pkg::PIX_W-1:0]   c_reg;
    logic [bir_pkg::PIX_W-1:0]   c_next;
    logic [bir_pkg::PIX_W-1:0]   top_reg;
    logic [bir_pkg::PIX_W-1:0]   top_next;
    logic [bir_pkg::PIX_W-1:0]   bot_reg;
    logic [bir_pkg::PIX_W-1:0]   bot_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [bir_pkg::PIX_W-1:0]   out_data_reg;
    logic [bir_pkg::PIX_W-1:0]   out_data_next;
    logic                        out_row_end_reg;
    logic                        out_row_end_next;
    logic                        out_frame_end_reg;
    logic                        out_frame_end_next;

    // clamp the configured sizes to the supported range
    always_comb
    begin
        if (cfg.src_width < bir_pkg::SRC_W_MIN)
            sw = bir_pkg::SRC_W_MIN;
        else if (cfg.src_width > bir_pkg::SRC_W_MAX)
            sw = bir_pkg::SRC_W_MAX;
        else
            sw = cfg.src_width;

        if (cfg.src_height < bir_pkg::SRC_H_MIN)
            sh = bir_pkg::SRC_H_MIN;
        else if (cfg.src_height > bir_pkg::SRC_H_MAX)
            sh = bir_pkg::SRC_H_MAX;
        else
            sh = cfg.src_height;

        if (cfg.dst_width < bir_pkg::DST_MIN)
            dw = bir_pkg::DST_MIN;
        else if (cfg.dst_width > bir_pkg::DST_MAX)
            dw = bir_pkg::DST_MAX;
        else
            dw = cfg.dst_width;

        if (cfg.dst_height < bir_pkg::DST_MIN)
            dh = bir_pkg::DST_MIN;
        else if (cfg.dst_height > bir_pkg::DST_MAX)
            dh = bir_pkg::DST_MAX;
        else
            dh = cfg.dst_height;
    end

    assign sw_m1 = sw - 1'b1;
    assign sh_m1 = sh - 1'b1;
    assign area  = {{bir_pkg::SH_W{1'b0}}, sw} * {{bir_pkg::SW_W{1'b0}}, sh};

    // neighbor coordinates, clamped to the last column and row
    assign x_int = u_reg[bir_pkg::POS_W-1:bir_pkg::FRAC_W];
    assign y_int = v_reg[bir_pkg::POS_W-1:bir_pkg::FRAC_W];
    assign xw    = u_reg[bir_pkg::FRAC_W-1:0];
    assign yw    = v_reg[bir_pkg::FRAC_W-1:0];
    assign x0    = (x_int > sw_m1) ? sw_m1 : x_int;
    assign y0    = (y_int > sh_m1) ? sh_m1 : y_int;
    assign x1    = (x0 == sw_m1) ? sw_m1 : x0 + 1'b1;
    assign y1    = (y0 == sh_m1) ? sh_m1 : y0 + 1'b1;

    assign row0_base = {{bir_pkg::SW_W{1'b0}}, y0} * {{bir_pkg::SH_W{1'b0}}, sw};
    assign row1_base = {{bir_pkg::SW_W{1'b0}}, y1} * {{bir_pkg::SH_W{1'b0}}, sw};

    always_comb
    begin
        case (cmd.sel)
            bir_pkg::SEL_A: rd_sum = row0_base + {{bir_pkg::SH_W{1'b0}}, x0};
            bir_pkg::SEL_B: rd_sum = row0_base + {{bir_pkg::SH_W{1'b0}}, x1};
            bir_pkg::SEL_C: rd_sum = row1_base + {{bir_pkg::SH_W{1'b0}}, x0};
            bir_pkg::SEL_D: rd_sum = row1_base + {{bir_pkg::SH_W{1'b0}}, x1};
            default:        rd_sum = row0_base;
        endcase
    end

    assign rd_addr = bir_pkg::to_addr(rd_sum);

    // load address: restart when past the source area, wrap after the last pixel
    assign ld_cur = (load_idx_reg >= area) ? '0 : load_idx_reg;
    assign ld_inc = {1'b0, ld_cur} + 1'b1;

    always_comb
    begin
        load_idx_next = load_idx_reg;
        if (cmd.load)
        begin
            load_idx_next = (ld_inc >= area) ? '0 : ld_inc[bir_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            store_mem[ld_cur] <= in_pixel;
        end
        if (cmd.read)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // interpolation: horizontal pass per row, then vertical pass
    always_comb
    begin
        a_next        = a_reg;
        c_next        = c_reg;
        top_next      = top_reg;
        bot_next      = bot_reg;
        out_data_next = out_data_reg;
        if (cmd.latch_a)
            a_next = rd_data_reg;
        if (cmd.latch_c)
            c_next = rd_data_reg;
        for (int ch = 0; ch < bir_pkg::NUM_CH; ch++)
        begin
            if (cmd.calc_top)
                top_next[ch*bir_pkg::CH_W +: bir_pkg::CH_W] =
                    lerp(a_reg[ch*bir_pkg::CH_W +: bir_pkg::CH_W],
                         rd_data_reg[ch*bir_pkg::CH_W +: bir_pkg::CH_W], xw);
            if (cmd.calc_bot)
                bot_next[ch*bir_pkg::CH_W +: bir_pkg::CH_W] =
                    lerp(c_reg[ch*bir_pkg::CH_W +: bir_pkg::CH_W],
                         rd_data_reg[ch*bir_pkg::CH_W +: bir_pkg::CH_W], xw);
            if (cmd.finish)
                out_data_next[ch*bir_pkg::CH_W +: bir_pkg::CH_W] =
                    lerp(top_reg[ch*bir_pkg::CH_W +: bir_pkg::CH_W],
                         bot_reg[ch*bir_pkg::CH_W +: bir_pkg::CH_W], yw);
        end
    end

    // raster position
    assign col_p1   = {1'b0, col_reg} + 1'b1;
    assign row_p1   = {1'b0, row_reg} + 1'b1;
    assign last_col = (col_p1 >= dw);
    assign last_row = (row_p1 >= dh);

    always_comb
    begin
        col_next           = col_reg;
        row_next           = row_reg;
        u_next             = u_reg;
        v_next             = v_reg;
        out_row_end_next   = out_row_end_reg;
        out_frame_end_next = out_frame_end_reg;
        if (cmd.finish)
        begin
            out_row_end_next   = last_col;
            out_frame_end_next = last_col && last_row;
            if (!last_col)
            begin
                col_next = col_p1[bir_pkg::DST_W-1:0];
                u_next   = u_reg + {1'b0, cfg.step_u};
            end
            else
            begin
                col_next = '0;
                u_next   = '0;
                if (!last_row)
                begin
                    row_next = row_p1[bir_pkg::DST_W-1:0];
                    v_next   = v_reg + {1'b0, cfg.step_v};
                end
                else
                begin
                    row_next = '0;
                    v_next   = '0;
                end
            end
        end
    end

    // output register: hold until taken
    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign m_tuser[0]    = out_row_end_reg;
    assign m_tlast       = out_frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            u_reg         <= '0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            load_idx_reg  <= load_idx_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            u_reg         <= u_next;
            v_reg         <= v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg             <= a_next;
        c_reg             <= c_next;
        top_reg           <= top_next;
        bot_reg           <= bot_next;
        out_data_reg      <= out_data_next;
        out_row_end_reg   <= out_row_end_next;
        out_frame_end_reg <= out_frame_end_next;
    end

    `BIR_ASSERT_NXT(a_finish_fills_output, clk, rst_n, cmd.finish, out_valid_reg)
    `BIR_ASSERT_IMP(a_frame_end_is_row_end, clk, rst_n, out_valid_reg && out_frame_end_reg, out_row_end_reg)
    `BIR_ASSERT_IMP(a_no_load_during_read, clk, rst_n, cmd.read, !cmd.load)

endmodule

### hdl/bilinear_image_resampler.sv
// Bilinear RGBA resampler. A slave beat with tuser 0 loads one source pixel into the
// on-chip pixel store (row-major, wrapping after width*height pixels) and is taken without
// leaving the idle state; a beat with tuser 1 requests the next destination pixel in raster
// order. No further beat is taken until that request's result is in the output register and
// the controller is idle again: the single read port of the pixel store fetches the four
// neighbors one per cycle, and the horizontal and vertical multiply passes each take a
// registered stage; a stalled master side adds its wait.
// The result is held in an output register with tuser = row end and tlast = frame end.
// Registers (APB, byte address 4*index): source width and height, destination width and
// height, and the 8.15 horizontal and vertical steps. The pixel store is not cleared at
// reset; load a full source image before requesting output.
module bilinear_image_resampler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bir_pkg::PIX_W-1:0]   s_tdata,   // in_red, in_green, in_blue, in_alpha
    input  logic [0:0]                  s_tuser,   // mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bir_pkg::PIX_W-1:0]   m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic [0:0]                  m_tuser,   // row_end
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bir_pkg::APB_AW-1:0]  paddr,
    input  logic [bir_pkg::APB_DW-1:0]  pwdata,
    output logic [bir_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    bir_pkg::cfg_t  cfg;
    bir_pkg::cmd_t  cmd;
    bir_pkg::stat_t stat;

    bir_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser[0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bir_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .in_pixel (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
